// File: hdl/htd_pkg.sv
// Shared types, codes and defaults for the code-tree decoder.
package htd_pkg;

  localparam int NODE_COUNT_DEF      = 512;
  localparam int MAX_CODE_LENGTH_DEF = 16;
  localparam int CODE_W              = 16;
  localparam int LEN_W               = 5;
  localparam int SYM_W               = 8;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0,
    ST_DECODED  = 3'd1,
    ST_STORED   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_FULL     = 3'd4,
    ST_CONFLICT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RD_ROOT  = 2'd0,
    RD_POS   = 2'd1,
    RD_CHILD = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic              func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              bit_req;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [SYM_W-1:0] decoded_symbol;
  } out_word_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    clr_rdata;
    logic    walk_init;
    logic    walk_step;
    logic    begin_chain;
    logic    wr_par;
    logic    wr_chain;
    logic    set_res;
    status_t res_code;
    logic    res_sym;
    logic    pos_clr;
    logic    pos_load;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_func;
    logic len_bad;
    logic tree_empty;
    logic pos_bad;
    logic node_leaf;
    logic child_missing;
    logic walk_end;
    logic cap_ok;
    logic chain_last;
  } dp_stat_t;

endpackage

// File: hdl/htd_datapath.sv
// Node store, walk registers, decode position and result registers.
module htd_datapath #(
  parameter int NODE_COUNT      = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = htd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  htd_pkg::in_word_t  in_word,
  input  htd_pkg::dp_cmd_t   cmd,
  output htd_pkg::dp_stat_t  stat,
  output htd_pkg::out_word_t out_word
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int SW = (CW > 6 ? CW : 6) + 1;
  localparam int EW = 1 + htd_pkg::SYM_W + 2 * IW;
  localparam int LW = htd_pkg::LEN_W;
  localparam logic [LW:0] MAX_LEN = (LW + 1)'(MAX_CODE_LENGTH);

  logic [EW-1:0] mem [NODE_COUNT];
  logic [EW-1:0] rdata_r;

  htd_pkg::in_word_t  item_r, item_nxt;
  htd_pkg::out_word_t res_r, res_nxt;
  htd_pkg::out_word_t out_r, out_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] par_r, par_nxt;
  logic [LW-1:0] depth_r, depth_nxt;

  logic                     node_leaf;
  logic [htd_pkg::SYM_W-1:0] node_sym;
  logic [IW-1:0]            child0, child1, child;
  logic [LW-1:0]            bit_pos;
  logic [htd_pkg::CODE_W-1:0] code_sh;
  logic                     cbit, dir;
  logic                     tree_empty, chain_last;
  logic [SW-1:0]            need;
  logic [IW-1:0]            cur_inc;
  logic [IW-1:0]            rd_addr, wr_addr;
  logic [EW-1:0]            wr_data;
  logic                     wr_en;

  assign node_leaf = rdata_r[EW-1];
  assign node_sym  = rdata_r[EW-2 -: htd_pkg::SYM_W];
  assign child1    = rdata_r[2*IW-1:IW];
  assign child0    = rdata_r[IW-1:0];

  assign bit_pos    = item_r.code_length - depth_r - LW'(1);
  assign code_sh    = item_r.code_bits >> bit_pos;
  assign cbit       = code_sh[0];
  assign dir        = (item_r.func == htd_pkg::FUNC_DECODE) ? item_r.bit_req : cbit;
  assign child      = dir ? child1 : child0;
  assign tree_empty = (used_r == '0);
  assign chain_last = (depth_r == item_r.code_length);
  assign cur_inc    = cur_r + IW'(1);

  always_comb begin
    if (tree_empty) begin
      need = SW'(item_r.code_length) + SW'(1);
    end else begin
      need = SW'(item_r.code_length) - SW'(depth_r);
    end
  end

  always_comb begin
    stat.in_func       = in_word.func;
    stat.len_bad       = (item_r.code_length == '0) || ({1'b0, item_r.code_length} > MAX_LEN);
    stat.tree_empty    = tree_empty;
    stat.pos_bad       = (CW'(pos_r) >= used_r);
    stat.node_leaf     = node_leaf;
    stat.child_missing = (child == '0) || (CW'(child) >= used_r);
    stat.walk_end      = (({1'b0, depth_r} + (LW + 1)'(1)) == {1'b0, item_r.code_length});
    stat.cap_ok        = (SW'(used_r) + need) <= SW'(NODE_COUNT);
    stat.chain_last    = chain_last;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      htd_pkg::RD_ROOT:  rd_addr = '0;
      htd_pkg::RD_POS:   rd_addr = pos_r;
      htd_pkg::RD_CHILD: rd_addr = child;
      default:           rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.wr_par | cmd.wr_chain;
  assign wr_addr = cmd.wr_par ? par_r : cur_r;

  always_comb begin
    wr_data = '0;
    if (cmd.wr_par) begin
      wr_data = rdata_r;
      if (cbit) begin
        wr_data[2*IW-1:IW] = cur_r;
      end else begin
        wr_data[IW-1:0] = cur_r;
      end
    end else if (chain_last) begin
      wr_data[EW-1]                     = 1'b1;
      wr_data[EW-2 -: htd_pkg::SYM_W]   = item_r.symbol;
    end else if (cbit) begin
      wr_data[2*IW-1:IW] = cur_inc;
    end else begin
      wr_data[IW-1:0] = cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end else if (cmd.clr_rdata) begin
      rdata_r <= '0;
    end
  end

  always_comb begin
    item_nxt  = item_r;
    cur_nxt   = cur_r;
    par_nxt   = par_r;
    depth_nxt = depth_r;
    used_nxt  = used_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    if (cmd.capture) begin
      item_nxt = in_word;
    end
    if (cmd.walk_init) begin
      cur_nxt   = '0;
      depth_nxt = '0;
    end
    if (cmd.walk_step) begin
      cur_nxt   = child;
      depth_nxt = depth_r + LW'(1);
    end
    if (cmd.begin_chain) begin
      if (tree_empty) begin
        par_nxt   = '0;
        cur_nxt   = IW'(1);
        depth_nxt = '0;
      end else begin
        par_nxt = cur_r;
        cur_nxt = used_r[IW-1:0];
      end
    end
    if (cmd.wr_par) begin
      depth_nxt = depth_r + LW'(1);
    end
    if (cmd.wr_chain) begin
      cur_nxt   = cur_inc;
      depth_nxt = depth_r + LW'(1);
      if (chain_last) begin
        used_nxt = CW'(cur_r) + CW'(1);
      end
    end
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end else if (cmd.pos_load) begin
      pos_nxt = cur_r;
    end
    if (cmd.set_res) begin
      res_nxt.status         = cmd.res_code;
      res_nxt.decoded_symbol = cmd.res_sym ? node_sym : '0;
    end
    if (cmd.out_load) begin
      out_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    cur_r   <= cur_nxt;
    par_r   <= par_nxt;
    depth_r <= depth_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      pos_r  <= '0;
    end else begin
      used_r <= used_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign out_word = out_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(NODE_COUNT))
    else $error("node count beyond store size");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) || (CW'(pos_r) < used_r))
    else $error("decode position outside allocated nodes");

  a_chain_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_chain |-> (CW'(cur_r) >= used_r) && (CW'(cur_r) < CW'(NODE_COUNT)))
    else $error("new node written over an allocated or missing entry");

endmodule

// File: hdl/htd_ctrl.sv
// Sequencer for load walks, node commits and decode steps.
module htd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  htd_pkg::dp_stat_t stat,
  output htd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_LD_START  = 9'b000000010,
    S_LD_EVAL   = 9'b000000100,
    S_LD_WPAR   = 9'b000001000,
    S_LD_WCHAIN = 9'b000010000,
    S_DC_START  = 9'b000100000,
    S_DC_EVAL1  = 9'b001000000,
    S_DC_EVAL2  = 9'b010000000,
    S_RESULT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (stat.in_func == htd_pkg::FUNC_DECODE) ? S_DC_START : S_LD_START;
        end
      end
      S_LD_START: begin
        priority if (stat.len_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_CONFLICT;
          state_nxt    = S_RESULT;
        end else if (stat.tree_empty) begin
          if (!stat.cap_ok) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = htd_pkg::ST_FULL;
            state_nxt    = S_RESULT;
          end else begin
            cmd.clr_rdata   = 1'b1;
            cmd.begin_chain = 1'b1;
            state_nxt       = S_LD_WPAR;
          end
        end else begin
          cmd.walk_init = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = htd_pkg::RD_ROOT;
          state_nxt     = S_LD_EVAL;
        end
      end
      S_LD_EVAL: begin
        priority if (stat.node_leaf) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_CONFLICT;
          state_nxt    = S_RESULT;
        end else if (stat.child_missing) begin
          if (!stat.cap_ok) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = htd_pkg::ST_FULL;
            state_nxt    = S_RESULT;
          end else begin
            cmd.begin_chain = 1'b1;
            state_nxt       = S_LD_WPAR;
          end
        end else if (stat.walk_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_CONFLICT;
          state_nxt    = S_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = htd_pkg::RD_CHILD;
        end
      end
      S_LD_WPAR: begin
        cmd.wr_par = 1'b1;
        state_nxt  = S_LD_WCHAIN;
      end
      S_LD_WCHAIN: begin
        cmd.wr_chain = 1'b1;
        if (stat.chain_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_STORED;
          state_nxt    = S_RESULT;
        end
      end
      S_DC_START: begin
        if (stat.tree_empty || stat.pos_bad) begin
          cmd.pos_clr  = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_INVALID;
          state_nxt    = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = htd_pkg::RD_POS;
          state_nxt  = S_DC_EVAL1;
        end
      end
      S_DC_EVAL1: begin
        if (stat.node_leaf || stat.child_missing) begin
          cmd.pos_clr  = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = htd_pkg::ST_INVALID;
          state_nxt    = S_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = htd_pkg::RD_CHILD;
          state_nxt     = S_DC_EVAL2;
        end
      end
      S_DC_EVAL2: begin
        cmd.set_res = 1'b1;
        if (stat.node_leaf) begin
          cmd.pos_clr  = 1'b1;
          cmd.res_sym  = 1'b1;
          cmd.res_code = htd_pkg::ST_DECODED;
        end else begin
          cmd.pos_load = 1'b1;
          cmd.res_code = htd_pkg::ST_CONSUMED;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/huffman_tree_decoder_unit.sv
// Top level of the code-tree loader and bit-serial symbol decoder.
// Decode word: reads the node at the decode position, then its child, one node read per cycle;
//   an invalid path ends early; the result waits while a stalled result is still on the output.
// Load word: walks existing nodes, then writes the parent link and new nodes, one node a cycle.
// Reset (rst_n low at a clock edge) empties the tree and returns the position to the root.
module huffman_tree_decoder_unit #(
  parameter int NODE_COUNT      = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = htd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  htd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output htd_pkg::out_word_t out_word
);

  htd_pkg::dp_cmd_t  cmd;
  htd_pkg::dp_stat_t stat;

  htd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  htd_datapath #(
    .NODE_COUNT      (NODE_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
